### hw/rtl/cbmt_pkg.sv
// cbmt_pkg: shared types and constants of the counter bank with max tracking
// no dependencies; imported by the cell and the top level
`default_nettype none

package cbmt_pkg;

	localparam int CBMT_NUM_COUNTERS = 64;
	localparam int CBMT_COUNT_WIDTH  = 16;

	typedef logic [1:0] op_t;

	localparam op_t OP_INC   = 2'd0;
	localparam op_t OP_DEC   = 2'd1;
	localparam op_t OP_CLR   = 2'd2;
	localparam op_t OP_QUERY = 2'd3;

	// command broadcast from the control to every cell
	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_t;

endpackage

`default_nettype wire

### hw/rtl/cbmt_if.sv
// cbmt_if: valid/ready channels of the counter bank, request and response
// no dependencies; widths follow the top level parameters
`default_nettype none

interface cbmt_req_if #(
	parameter int IDX_W = 6
);
	logic             valid;
	logic             ready;
	logic [1:0]       op;
	logic [IDX_W-1:0] counter_index;

	modport source (output valid, op, counter_index, input ready);
	modport sink   (input valid, op, counter_index, output ready);
endinterface

interface cbmt_rsp_if #(
	parameter int CNT_W  = 16,
	parameter int MULT_W = 7
);
	logic                     valid;
	logic                     ready;
	logic signed [CNT_W-1:0]  counter_value;
	logic signed [CNT_W-1:0]  max_value;
	logic        [MULT_W-1:0] max_multiplicity;

	modport source (output valid, counter_value, max_value, max_multiplicity, input ready);
	modport sink   (input valid, counter_value, max_value, max_multiplicity, output ready);
endinterface

`default_nettype wire

### hw/rtl/cbmt_cell.sv
// cbmt_cell: one counter of the bank and one step of the max/count scan chain
// depends on cbmt_pkg
`default_nettype none

module cbmt_cell
	import cbmt_pkg::*;
#(
	parameter int CNT_W  = CBMT_COUNT_WIDTH,
	parameter int IDX_W  = 6,
	parameter int MULT_W = 7,
	parameter int CELL_ID = 0
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	input  wire logic [IDX_W-1:0]         idx,
	input  wire logic                     tok_in_valid,
	input  wire logic signed [CNT_W-1:0]  best_in,
	input  wire logic        [MULT_W-1:0] cnt_in,
	input  wire logic signed [CNT_W-1:0]  val_in,
	output logic                          tok_out_valid,
	output logic signed [CNT_W-1:0]       best_out,
	output logic        [MULT_W-1:0]      cnt_out,
	output logic signed [CNT_W-1:0]       val_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);
	localparam logic signed [CNT_W-1:0] CNT_MAXV = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MINV = {1'b1, {(CNT_W-1){1'b0}}};

	logic signed [CNT_W-1:0] count_q;
	logic signed [CNT_W-1:0] count_nxt;
	logic                    hit;

	assign hit = (idx == MY_IDX);

	always_comb begin
		case (cmd.op)
			OP_INC:  count_nxt = (count_q != CNT_MAXV) ? count_q + CNT_W'(1) : count_q;
			OP_DEC:  count_nxt = (count_q != CNT_MINV) ? count_q - CNT_W'(1) : count_q;
			OP_CLR:  count_nxt = '0;
			default: count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.valid && hit) begin
			count_q <= count_nxt;
		end
	end

	// scan token: running max, how many hold it, and the addressed counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_valid <= 1'b0;
		end else begin
			tok_out_valid <= tok_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in_valid) begin
			if (cnt_in == '0 || count_q > best_in) begin
				best_out <= count_q;
				cnt_out  <= MULT_W'(1);
			end else if (count_q == best_in) begin
				best_out <= best_in;
				cnt_out  <= cnt_in + MULT_W'(1);
			end else begin
				best_out <= best_in;
				cnt_out  <= cnt_in;
			end
			val_out <= hit ? count_q : val_in;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/counter_bank_with_max_tracking_unit.sv
// counter_bank_with_max_tracking_unit: top level, command control, cell chain, result regs
// depends on cbmt_pkg, cbmt_if (cbmt_req_if, cbmt_rsp_if) and cbmt_cell
//
//   channel  dir  payload                                            handshake
//   req      in   op, counter_index                                  valid/ready
//   rsp      out  counter_value, max_value, max_multiplicity          valid/ready
//
// one item at a time: the command register updates the addressed cell, then a scan token
// walks the cell chain one cell per cycle, then the result reaches the response register
// the response register is separate, so the next item is taken while a result waits
// arst_n clears every counter to zero and empties the pipeline
// a stalled response holds the scan result until the response register frees up
`default_nettype none

module counter_bank_with_max_tracking_unit
	import cbmt_pkg::*;
#(
	parameter int NUM_COUNTERS = CBMT_NUM_COUNTERS,
	parameter int COUNT_WIDTH  = CBMT_COUNT_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	cbmt_req_if.sink   req,
	cbmt_rsp_if.source rsp
);

	localparam int IDX_W  = $clog2(NUM_COUNTERS);
	localparam int MULT_W = $clog2(NUM_COUNTERS + 1);

	logic             busy_q;
	logic             cmd_valid_q;
	op_t              cmd_op_q;
	logic [IDX_W-1:0] cmd_idx_q;
	logic             inject_q;
	cmd_t             cmd;
	logic             accept;
	logic             out_load;

	logic                     tok_valid [0:NUM_COUNTERS];
	logic signed [COUNT_WIDTH-1:0] tok_best [0:NUM_COUNTERS];
	logic        [MULT_W-1:0]      tok_cnt  [0:NUM_COUNTERS];
	logic signed [COUNT_WIDTH-1:0] tok_val  [0:NUM_COUNTERS];

	logic                          res_valid_q;
	logic signed [COUNT_WIDTH-1:0] res_best_q;
	logic        [MULT_W-1:0]      res_cnt_q;
	logic signed [COUNT_WIDTH-1:0] res_val_q;

	logic                          out_valid_q;
	logic signed [COUNT_WIDTH-1:0] out_best_q;
	logic        [MULT_W-1:0]      out_cnt_q;
	logic signed [COUNT_WIDTH-1:0] out_val_q;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign out_load  = res_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cmd_valid_q <= 1'b0;
			inject_q    <= 1'b0;
		end else begin
			cmd_valid_q <= accept;
			inject_q    <= cmd_valid_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_op_q  <= req.op;
			cmd_idx_q <= req.counter_index;
		end
	end

	assign cmd.valid = cmd_valid_q;
	assign cmd.op    = cmd_op_q;

	// empty token enters the chain once the addressed cell has updated
	assign tok_valid[0] = inject_q;
	assign tok_best[0]  = '0;
	assign tok_cnt[0]   = '0;
	assign tok_val[0]   = '0;

	for (genvar k = 0; k < NUM_COUNTERS; k++) begin : g_cell
		cbmt_cell #(
			.CNT_W  (COUNT_WIDTH),
			.IDX_W  (IDX_W),
			.MULT_W (MULT_W),
			.CELL_ID(k)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.idx          (cmd_idx_q),
			.tok_in_valid (tok_valid[k]),
			.best_in      (tok_best[k]),
			.cnt_in       (tok_cnt[k]),
			.val_in       (tok_val[k]),
			.tok_out_valid(tok_valid[k+1]),
			.best_out     (tok_best[k+1]),
			.cnt_out      (tok_cnt[k+1]),
			.val_out      (tok_val[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_valid[NUM_COUNTERS]) begin
				res_valid_q <= 1'b1;
			end else if (out_load) begin
				res_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid[NUM_COUNTERS]) begin
			res_best_q <= tok_best[NUM_COUNTERS];
			res_cnt_q  <= tok_cnt[NUM_COUNTERS];
			res_val_q  <= tok_val[NUM_COUNTERS];
		end
		if (out_load) begin
			out_best_q <= res_best_q;
			out_cnt_q  <= res_cnt_q;
			out_val_q  <= res_val_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.counter_value    = out_val_q;
	assign rsp.max_value        = out_best_q;
	assign rsp.max_multiplicity = out_cnt_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted item did not mark the unit busy");

	a_res_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> busy_q)
		else $error("scan result pending while unit idle");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!cmd_valid_q && !inject_q && !tok_valid[NUM_COUNTERS]))
		else $error("command or scan token active while unit idle");

	a_mult_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.max_multiplicity != '0))
		else $error("response reports no counter at the maximum");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid[NUM_COUNTERS] |-> (busy_q && !res_valid_q))
		else $error("scan finished with no item in flight or result still pending");

endmodule

`default_nettype wire

### test/counter_bank_with_max_tracking_unit_tb.sv
// counter_bank_with_max_tracking_unit_tb: self-checking bench for the counter bank with max tracking
// depends on cbmt_pkg, cbmt_if and counter_bank_with_max_tracking_unit; an in-bench bank model
// predicts every response, with random sender bursts and receiver stalls
`timescale 1ns / 100ps

module counter_bank_with_max_tracking_unit_tb;
	import cbmt_pkg::*;

	localparam int NUM    = CBMT_NUM_COUNTERS;
	localparam int CW     = CBMT_COUNT_WIDTH;
	localparam int IDX_W  = 6;
	localparam int MULT_W = 7;
	localparam int CYCLE_LIMIT = 600000;

	localparam logic signed [CW-1:0] COUNT_TOP = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COUNT_BOT = {1'b1, {(CW-1){1'b0}}};

	typedef struct {
		logic signed [CW-1:0] value;
		logic signed [CW-1:0] peak_value;
		logic [MULT_W-1:0]    peak_count;
	} bank_result_t;

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   fail_count = 0;

	logic signed [CW-1:0] bank_model [NUM];
	logic signed [CW-1:0] model_peak;
	logic [MULT_W-1:0]    model_peak_count;
	bank_result_t         pending_results [$];

	int   tx_burst_left;
	int   rx_run = 0;
	int   rx_mode = 0;
	logic rx_level = 1'b0;

	cbmt_req_if #(.IDX_W(IDX_W)) req_ch ();
	cbmt_rsp_if #(.CNT_W(CW), .MULT_W(MULT_W)) rsp_ch ();

	counter_bank_with_max_tracking_unit #(
		.NUM_COUNTERS(NUM),
		.COUNT_WIDTH (CW)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("counter_bank_with_max_tracking_unit_tb failed");
			$finish;
		end
	end

	function automatic void bank_rescan();
		logic signed [CW-1:0] best;
		logic [MULT_W-1:0]    n;
		best = bank_model[0];
		n = '0;
		for (int k = 1; k < NUM; k++) begin
			if (bank_model[k] > best) best = bank_model[k];
		end
		for (int k = 0; k < NUM; k++) begin
			if (bank_model[k] == best) n++;
		end
		model_peak = best;
		model_peak_count = n;
	endfunction

	function automatic void bank_apply(op_t op, logic [IDX_W-1:0] idx);
		logic signed [CW-1:0] v;
		bank_result_t r;
		v = '0;
		if (int'(idx) < NUM) begin
			v = bank_model[idx];
			case (op)
				OP_INC: begin
					if (v != COUNT_TOP) v = v + CW'(1);
				end
				OP_DEC: begin
					if (v != COUNT_BOT) v = v - CW'(1);
				end
				OP_CLR: begin
					v = '0;
				end
				default: begin
				end
			endcase
			bank_model[idx] = v;
			bank_rescan();
		end
		r.value = v;
		r.peak_value = model_peak;
		r.peak_count = model_peak_count;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// response checker
	always @(posedge clk) begin
		bank_result_t r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected response: counter_value %0d", rsp_ch.counter_value);
				fail_count++;
			end else begin
				r = pending_results.pop_front();
				if (rsp_ch.counter_value !== r.value) begin
					$error("counter_value expected %0d actual %0d", r.value, rsp_ch.counter_value);
					fail_count++;
				end
				if (rsp_ch.max_value !== r.peak_value) begin
					$error("max_value expected %0d actual %0d", r.peak_value, rsp_ch.max_value);
					fail_count++;
				end
				if (rsp_ch.max_multiplicity !== r.peak_count) begin
					$error("max_multiplicity expected %0d actual %0d", r.peak_count,
						rsp_ch.max_multiplicity);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rx_run == 0) begin
				if ($urandom_range(0, 15) == 0) rx_mode = $urandom_range(0, 2);
				case (rx_mode)
					0: begin
						rx_level = 1'b1;
						rx_run = $urandom_range(20, 200);
					end
					1: begin
						rx_level = ~rx_level;
						rx_run = $urandom_range(1, 4);
					end
					default: begin
						rx_level = ~rx_level;
						rx_run = rx_level ? $urandom_range(1, 10) : $urandom_range(10, 60);
					end
				endcase
				rsp_ch.ready <= rx_level;
			end else begin
				rx_run--;
			end
		end
	end

	task automatic send_item(op_t op, logic [IDX_W-1:0] idx);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.counter_index <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		bank_apply(op, idx);
		if (tx_burst_left > 0) begin
			tx_burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx_burst_left = $urandom_range(0, 12);
		end
	endtask

	function automatic op_t pick_op();
		int w;
		w = $urandom_range(0, 9);
		if (w < 4) return OP_INC;
		if (w < 7) return OP_DEC;
		if (w < 8) return OP_CLR;
		return OP_QUERY;
	endfunction

	task automatic test_reset_state();
		send_item(OP_QUERY, 6'd0);
		send_item(OP_QUERY, 6'd63);
	endtask

	task automatic test_inc_dec();
		send_item(OP_INC, 6'd0);
		send_item(OP_INC, 6'd0);
		send_item(OP_INC, 6'd63);
		send_item(OP_DEC, 6'd0);
		send_item(OP_DEC, 6'd63);
		send_item(OP_DEC, 6'd63);
		send_item(OP_QUERY, 6'd63);
	endtask

	task automatic test_clear();
		send_item(OP_INC, 6'd5);
		send_item(OP_INC, 6'd5);
		send_item(OP_INC, 6'd5);
		// only counter at the max is cleared
		send_item(OP_CLR, 6'd5);
		send_item(OP_DEC, 6'd7);
		send_item(OP_DEC, 6'd7);
		// cleared counter comes from the lowest group
		send_item(OP_CLR, 6'd7);
		send_item(OP_CLR, 6'd63);
		send_item(OP_CLR, 6'd42);
		send_item(OP_QUERY, 6'd21);
	endtask

	task automatic test_bank_sweep();
		logic [IDX_W-1:0] order [NUM];
		logic [IDX_W-1:0] t;
		int j;
		for (int k = 0; k < NUM; k++) order[k] = k[IDX_W-1:0];
		for (int pass = 0; pass < 2; pass++) begin
			for (int k = NUM - 1; k > 0; k--) begin
				j = $urandom_range(0, k);
				t = order[k];
				order[k] = order[j];
				order[j] = t;
			end
			for (int k = 0; k < NUM; k++) begin
				send_item(OP_DEC, order[k]);
				if ($urandom_range(0, 7) == 0)
					send_item(OP_QUERY, IDX_W'($urandom_range(0, NUM - 1)));
			end
		end
		// whole bank negative, clears lift a few back to zero
		for (int k = 0; k < 3; k++) send_item(OP_CLR, IDX_W'($urandom_range(0, NUM - 1)));
	endtask

	task automatic test_random_mix();
		logic [IDX_W-1:0] hot [4];
		logic [IDX_W-1:0] idx;
		for (int phase = 0; phase < 5; phase++) begin
			for (int k = 0; k < 4; k++) hot[k] = IDX_W'($urandom_range(0, NUM - 1));
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 9) < 7) idx = hot[$urandom_range(0, 3)];
				else idx = IDX_W'($urandom_range(0, NUM - 1));
				send_item(pick_op(), idx);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_QUERY;
		req_ch.counter_index <= '0;
		tx_burst_left = 0;
		for (int k = 0; k < NUM; k++) bank_model[k] = '0;
		model_peak = '0;
		model_peak_count = MULT_W'(NUM);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_inc_dec();
		test_clear();
		test_bank_sweep();
		test_random_mix();

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (NUM + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("counter_bank_with_max_tracking_unit_tb passed");
		end else begin
			$display("counter_bank_with_max_tracking_unit_tb failed");
		end
		$finish;
	end

endmodule
